FILE: src/gmc_pkg.sv
// Shared types and constants for the global minimum cut block.
package gmc_pkg;

   localparam int SUM_W    = 48;
   localparam int MASK_W   = 16;
   localparam int PHASE_W  = 4;
   localparam int NCOUNT_W = 5;
   localparam int THR_W    = 32;
   localparam int IN_W     = 32;
   localparam int NODE_LIM = 16;
   localparam int CSR_IDX_W = 1;

   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_START = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD  = 1'b1;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic             gt;
   } alu_res_type;

endpackage

FILE: src/global_min_cut_phases.sv
// Top level: Stoer-Wagner minimum cut sequencer around one shared adder.
// Load item: writes both mirrored matrix entries, the second from S_LD2; ignored if
// outside the node table. Start item: copies the weights into the scratch matrix,
// then per phase runs set-up, the ordering steps, the cut emit and the merge of the
// last node into the one ordered before it; new items are stalled meanwhile.
// Phase waits only on a full result register. Synchronous reset; weights undefined.
module global_min_cut_phases #(
   parameter int MAX_NODES   = 16,
   parameter int WEIGHT_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_command,
   input  logic [3:0]                    req_row,
   input  logic [3:0]                    req_col,
   input  logic [gmc_pkg::IN_W-1:0]      req_weight,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [gmc_pkg::PHASE_W-1:0]   rsp_phase_index,
   output logic [gmc_pkg::SUM_W-1:0]     rsp_cut_value,
   output logic [gmc_pkg::MASK_W-1:0]    rsp_member_mask,
   output logic                          rsp_below_threshold,
   output logic                          rsp_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [gmc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gmc_pkg::THR_W-1:0]     csr_data
);
   import gmc_pkg::*;

   localparam int NW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CW    = NW + 1;
   localparam int AW    = 2 * NW;
   localparam int DEPTH = 1 << AW;
   localparam int LIMIT = (MAX_NODES < NODE_LIM) ? MAX_NODES : NODE_LIM;
   localparam int KB    = (WEIGHT_BITS < IN_W) ? WEIGHT_BITS : IN_W;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_LD2  = 4'd1;
   localparam logic [3:0] S_CPR  = 4'd2;
   localparam logic [3:0] S_CPW  = 4'd3;
   localparam logic [3:0] S_PINI = 4'd4;
   localparam logic [3:0] S_SCAN = 4'd5;
   localparam logic [3:0] S_ACC  = 4'd6;
   localparam logic [3:0] S_EMIT = 4'd7;
   localparam logic [3:0] S_MRD  = 4'd8;
   localparam logic [3:0] S_MWA  = 4'd9;
   localparam logic [3:0] S_MWB  = 4'd10;

   // Loaded weights and the per-run scratch copy that merging rewrites
   logic [WEIGHT_BITS-1:0] wmat [DEPTH];
   logic [SUM_W-1:0]       scr  [DEPTH];

   logic [3:0]             state_ff, state_in;
   logic [NCOUNT_W-1:0]    ncfg_ff;
   logic [THR_W-1:0]       thr_ff;
   logic [CW-1:0]          n_ff, n_in;
   logic [CW-1:0]          p_ff, p_in;
   logic [CW-1:0]          step_ff, step_in;
   logic [CW-1:0]          j_ff, j_in;
   logic [AW-1:0]          k_ff, k_in;
   logic [AW-1:0]          ld2_addr_ff, ld2_addr_in;
   logic [WEIGHT_BITS-1:0] ld2_data_ff, ld2_data_in;
   logic [NW-1:0]          last_ff, last_in;
   logic [NW-1:0]          prev_ff, prev_in;
   logic [NW-1:0]          best_ff, best_in;
   logic [SUM_W-1:0]       best_val_ff, best_val_in;
   logic                   found_ff, found_in;
   logic [MAX_NODES-1:0]   active_ff, active_in;
   logic [MAX_NODES-1:0]   order_ff, order_in;
   logic [MAX_NODES-1:0]   members_ff [MAX_NODES];
   logic [MAX_NODES-1:0]   members_in [MAX_NODES];
   logic [SUM_W-1:0]       att_ff [MAX_NODES];
   logic [SUM_W-1:0]       att_in [MAX_NODES];
   logic [SUM_W-1:0]       msum_ff, msum_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [PHASE_W-1:0]     rsp_phase_ff, rsp_phase_in;
   logic [SUM_W-1:0]       rsp_cut_ff, rsp_cut_in;
   logic [MAX_NODES-1:0]   rsp_mask_ff, rsp_mask_in;
   logic                   rsp_below_ff, rsp_below_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [WEIGHT_BITS-1:0] wrd_ff;
   logic [SUM_W-1:0]       rda_ff, rdb_ff;
   logic [AW-1:0]          addr_a, addr_b;

   logic                   wm_we;
   logic [AW-1:0]          wm_addr;
   logic [WEIGHT_BITS-1:0] wm_data;
   logic                   sc_we;
   logic [AW-1:0]          sc_addr;
   logic [SUM_W-1:0]       sc_data;

   logic [SUM_W-1:0]       alu_a, alu_b;
   alu_res_type            alu_res;

   logic                   req_acc;
   logic                   rsp_acc;
   logic                   in_range;
   logic [NW-1:0]          jn;
   logic [CW-1:0]          n_clamp;
   logic [CW:0]            remain;
   logic [WEIGHT_BITS-1:0] wval;
   logic [MAX_NODES-1:0]   mt;

   gmc_alu u_alu (
      .op_a    (alu_a),
      .op_b    (alu_b),
      .cmp_ref (best_val_ff),
      .res     (alu_res)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign rsp_acc   = rsp_valid_ff && !rsp_stall;
   assign csr_ready = 1'b1;

   assign jn   = j_ff[NW-1:0];
   assign wval = WEIGHT_BITS'(req_weight[KB-1:0]);
   assign mt   = members_ff[last_ff];
   assign in_range = (32'(req_row) < MAX_NODES) && (32'(req_col) < MAX_NODES);

   always_comb begin
      priority if (ncfg_ff < NCOUNT_W'(2)) begin
         n_clamp = CW'(2);
      end else if (32'(ncfg_ff) > LIMIT) begin
         n_clamp = CW'(LIMIT);
      end else begin
         n_clamp = CW'(ncfg_ff);
      end
   end

   // active nodes in this phase: steps run while step+1 < n-p
   assign remain = {1'b0, n_ff} - {1'b0, p_ff};

   always_comb begin
      alu_a = rda_ff;
      alu_b = rdb_ff;
      if (state_ff == S_ACC) begin
         alu_a = att_ff[jn];
         alu_b = rda_ff;
      end
   end

   always_comb begin
      addr_a = {last_ff, jn};
      addr_b = {last_ff, jn};
      if (state_ff == S_MRD) begin
         addr_a = {prev_ff, jn};
         addr_b = {last_ff, jn};
      end
   end

   // Memory ports
   always_ff @(posedge clock) begin
      if (wm_we) begin
         wmat[wm_addr] <= wm_data;
      end
      wrd_ff <= wmat[k_ff];
   end

   always_ff @(posedge clock) begin
      if (sc_we) begin
         scr[sc_addr] <= sc_data;
      end
      rda_ff <= scr[addr_a];
      rdb_ff <= scr[addr_b];
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      p_in         = p_ff;
      step_in      = step_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      ld2_addr_in  = ld2_addr_ff;
      ld2_data_in  = ld2_data_ff;
      last_in      = last_ff;
      prev_in      = prev_ff;
      best_in      = best_ff;
      best_val_in  = best_val_ff;
      found_in     = found_ff;
      active_in    = active_ff;
      order_in     = order_ff;
      members_in   = members_ff;
      att_in       = att_ff;
      msum_in      = msum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_acc;
      rsp_phase_in = rsp_phase_ff;
      rsp_cut_in   = rsp_cut_ff;
      rsp_mask_in  = rsp_mask_ff;
      rsp_below_in = rsp_below_ff;
      rsp_last_in  = rsp_last_ff;
      wm_we        = 1'b0;
      wm_addr      = {NW'(req_row), NW'(req_col)};
      wm_data      = wval;
      sc_we        = 1'b0;
      sc_addr      = k_ff;
      sc_data      = SUM_W'(wrd_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (req_command == CMD_LOAD) begin
                  // write both halves of the symmetric pair; hold the weight
                  if (in_range) begin
                     wm_we       = 1'b1;
                     ld2_addr_in = {NW'(req_col), NW'(req_row)};
                     ld2_data_in = wval;
                     state_in    = S_LD2;
                  end
               end else begin
                  n_in      = n_clamp;
                  p_in      = '0;
                  k_in      = '0;
                  active_in = '1;
                  for (int i = 0; i < MAX_NODES; i++) begin
                     members_in[i]    = '0;
                     members_in[i][i] = 1'b1;
                  end
                  state_in = S_CPR;
               end
            end
         end
         S_LD2: begin
            wm_we    = 1'b1;
            wm_addr  = ld2_addr_ff;
            wm_data  = ld2_data_ff;
            state_in = S_IDLE;
         end
         S_CPR: begin
            state_in = S_CPW;
         end
         S_CPW: begin
            sc_we = 1'b1;
            if (&k_ff) begin
               state_in = S_PINI;
            end else begin
               k_in     = k_ff + AW'(1);
               state_in = S_CPR;
            end
         end
         S_PINI: begin
            for (int i = 0; i < MAX_NODES; i++) begin
               att_in[i] = '0;
            end
            order_in    = MAX_NODES'(1);
            last_in     = '0;
            prev_in     = '0;
            step_in     = '0;
            j_in        = '0;
            found_in    = 1'b0;
            best_in     = '0;
            best_val_in = '0;
            state_in    = S_SCAN;
         end
         S_SCAN: begin
            if (j_ff == n_ff) begin
               // close the ordering step
               prev_in   = last_ff;
               last_in   = best_ff;
               order_in  = order_ff | (MAX_NODES'(1) << best_ff);
               step_in   = step_ff + CW'(1);
               j_in      = '0;
               found_in  = 1'b0;
               if (({1'b0, step_ff} + (CW+1)'(2)) < remain) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_EMIT;
               end
            end else if (active_ff[jn] && !order_ff[jn]) begin
               state_in = S_ACC;
            end else begin
               j_in = j_ff + CW'(1);
            end
         end
         S_ACC: begin
            att_in[jn] = alu_res.sum;
            if (!found_ff || alu_res.gt) begin
               found_in    = 1'b1;
               best_in     = jn;
               best_val_in = alu_res.sum;
            end
            j_in     = j_ff + CW'(1);
            state_in = S_SCAN;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_phase_in = PHASE_W'(p_ff);
               rsp_cut_in   = best_val_ff;
               rsp_mask_in  = mt;
               rsp_below_in = best_val_ff < SUM_W'(thr_ff);
               rsp_last_in  = ({1'b0, p_ff} + (CW+1)'(2)) == {1'b0, n_ff};
               // fold the last node into the one ordered before it
               active_in[last_ff] = 1'b0;
               for (int i = 0; i < MAX_NODES; i++) begin
                  if (prev_ff == NW'(i)) begin
                     members_in[i] = members_ff[i] | mt;
                  end
               end
               members_in[last_ff] = '0;
               j_in     = '0;
               state_in = S_MRD;
            end
         end
         S_MRD: begin
            if (j_ff == n_ff) begin
               p_in = p_ff + CW'(1);
               if (({1'b0, p_ff} + (CW+1)'(2)) == {1'b0, n_ff}) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = S_PINI;
               end
            end else if (active_ff[jn] && (jn != prev_ff)) begin
               state_in = S_MWA;
            end else begin
               j_in = j_ff + CW'(1);
            end
         end
         S_MWA: begin
            sc_we    = 1'b1;
            sc_addr  = {prev_ff, jn};
            sc_data  = alu_res.sum;
            msum_in  = alu_res.sum;
            state_in = S_MWB;
         end
         S_MWB: begin
            sc_we    = 1'b1;
            sc_addr  = {jn, prev_ff};
            sc_data  = msum_ff;
            j_in     = j_ff + CW'(1);
            state_in = S_MRD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         ncfg_ff      <= NCOUNT_W'(16);
         thr_ff       <= THR_W'(131072);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_NODE_COUNT: ncfg_ff <= csr_data[NCOUNT_W-1:0];
               CSR_THRESHOLD:  thr_ff  <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      p_ff         <= p_in;
      step_ff      <= step_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      ld2_addr_ff  <= ld2_addr_in;
      ld2_data_ff  <= ld2_data_in;
      last_ff      <= last_in;
      prev_ff      <= prev_in;
      best_ff      <= best_in;
      best_val_ff  <= best_val_in;
      found_ff     <= found_in;
      active_ff    <= active_in;
      order_ff     <= order_in;
      members_ff   <= members_in;
      att_ff       <= att_in;
      msum_ff      <= msum_in;
      rsp_phase_ff <= rsp_phase_in;
      rsp_cut_ff   <= rsp_cut_in;
      rsp_mask_ff  <= rsp_mask_in;
      rsp_below_ff <= rsp_below_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_phase_index     = rsp_phase_ff;
   assign rsp_cut_value       = rsp_cut_ff;
   assign rsp_below_threshold = rsp_below_ff;
   assign rsp_last            = rsp_last_ff;

   // member mask is one bit per original node, zero above the node table
   generate
      for (genvar b = 0; b < MASK_W; b++) begin : g_mask
         if (b < MAX_NODES) begin : g_bit
            assign rsp_member_mask[b] = rsp_mask_ff[b];
         end else begin : g_zero
            assign rsp_member_mask[b] = 1'b0;
         end
      end
   endgenerate

endmodule

FILE: src/gmc_alu.sv
// Shared saturating adder and magnitude compare.
module gmc_alu (
   input  logic [gmc_pkg::SUM_W-1:0] op_a,
   input  logic [gmc_pkg::SUM_W-1:0] op_b,
   input  logic [gmc_pkg::SUM_W-1:0] cmp_ref,
   output gmc_pkg::alu_res_type      res
);
   import gmc_pkg::*;

   logic [SUM_W:0] wide;

   always_comb begin
      wide = {1'b0, op_a} + {1'b0, op_b};
      // clamp on carry out
      res.sum = wide[SUM_W] ? SUM_MAX : wide[SUM_W-1:0];
      res.gt  = res.sum > cmp_ref;
   end

endmodule

FILE: src/gmc_checker.sv
// Port-level checks for the global minimum cut block, bound to the top level.
module gmc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        req_command,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic                        rsp_last,
   input logic [gmc_pkg::SUM_W-1:0]   rsp_cut_value
);
   import gmc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cut_value))
      else $error("stalled result item changed");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_command == CMD_START) |=> req_stall)
      else $error("block took a new item right after a start");

   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> req_stall)
      else $error("block idle before the final phase");

endmodule

bind global_min_cut_phases gmc_checker u_gmc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_command   (req_command),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_last      (rsp_last),
   .rsp_cut_value (rsp_cut_value)
);

FILE: verif/tb_global_min_cut_phases.sv
// Self-checking testbench for the global minimum cut block.
`timescale 1ns / 100ps

module tb_global_min_cut_phases;
   import gmc_pkg::*;

   typedef struct {
      logic             command;
      logic [3:0]       row;
      logic [3:0]       col;
      logic [IN_W-1:0]  weight;
   } graph_item_type;

   typedef struct {
      logic [PHASE_W-1:0] phase_index;
      logic [SUM_W-1:0]   cut_value;
      logic [MASK_W-1:0]  member_mask;
      logic               below_threshold;
      logic               last;
   } phase_cut_type;

   localparam int IDLE_NONE = 0, IDLE_SEND = 1, IDLE_RECV = 2, IDLE_BOTH = 3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_command = 1'b0;
   logic [3:0]            req_row = '0;
   logic [3:0]            req_col = '0;
   logic [IN_W-1:0]       req_weight = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [PHASE_W-1:0]    rsp_phase_index;
   logic [SUM_W-1:0]      rsp_cut_value;
   logic [MASK_W-1:0]     rsp_member_mask;
   logic                  rsp_below_threshold;
   logic                  rsp_last;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [THR_W-1:0]      csr_data = '0;

   global_min_cut_phases u_top (.*);

   always #5 clock = ~clock;

   // Stimulus plumbing and predictor state
   graph_item_type    pending_items[$];
   phase_cut_type     expected_cuts[$];
   logic              req_fire = 1'b0;
   int                idle_mode = IDLE_NONE;
   logic [4:0]        node_count_reg = 5'd16;
   logic [THR_W-1:0]  threshold_reg = 32'd131072;
   logic [SUM_W-1:0]  weights[16][16];
   bit                planned_load[16][16];
   int                mismatches = 0;
   int                cuts_seen = 0;
   int                starts_sent = 0;
   int                loads_sent = 0;

   function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
   endfunction

   function automatic int clamp_nodes(logic [4:0] v);
      if (v < 2) return 2;
      if (v > NODE_LIM) return NODE_LIM;
      return int'(v);
   endfunction

   // Run every phase of one cut computation on a scratch copy; queue each phase cut.
   task automatic predict_cut_run();
      logic [SUM_W-1:0]  scr[16][16];
      logic [SUM_W-1:0]  attach[16];
      logic [MASK_W-1:0] members[16];
      logic [15:0]       active, ordered;
      logic [SUM_W-1:0]  best_val;
      int                n, best, last_node, prev_node;
      bit                found;
      phase_cut_type     pc;
      n = clamp_nodes(node_count_reg);
      scr = weights;
      active = '1;
      for (int i = 0; i < 16; i++) members[i] = MASK_W'(1) << i;
      for (int p = 0; p + 1 < n; p++) begin
         for (int i = 0; i < 16; i++) attach[i] = '0;
         ordered = 16'd1;
         last_node = 0;
         prev_node = 0;
         for (int step = 0; step + 1 < n - p; step++) begin
            found = 0;
            best = 0;
            best_val = '0;
            for (int j = 0; j < n; j++) begin
               if (!active[j] || ordered[j]) continue;
               attach[j] = sat_sum(attach[j], scr[last_node][j]);
               // strict compare: ties go to the lowest index
               if (!found || attach[j] > best_val) begin
                  found = 1;
                  best = j;
                  best_val = attach[j];
               end
            end
            prev_node = last_node;
            last_node = best;
            ordered[best] = 1'b1;
         end
         pc.phase_index     = PHASE_W'(p);
         pc.cut_value       = attach[last_node];
         pc.member_mask     = members[last_node];
         pc.below_threshold = attach[last_node] < SUM_W'(threshold_reg);
         pc.last            = (p + 2 == n);
         expected_cuts = {expected_cuts, pc};
         // fold the last node into the one ordered before it
         active[last_node] = 1'b0;
         members[prev_node] |= members[last_node];
         members[last_node] = '0;
         for (int j = 0; j < n; j++) begin
            if (!active[j] || j == prev_node) continue;
            scr[prev_node][j] = sat_sum(scr[prev_node][j], scr[last_node][j]);
            scr[j][prev_node] = scr[prev_node][j];
         end
      end
   endtask

   function automatic bit idle_now();
      case (idle_mode)
         IDLE_NONE: return 0;
         IDLE_BOTH: return $urandom_range(99) < 6;
         default:   return $urandom_range(99) < 83;
      endcase
   endfunction

   // Driver: present the next item at the falling edge once the last one is taken.
   always @(negedge clock) begin
      graph_item_type it;
      if (!reset) begin
         if (!req_valid || req_fire) begin
            if (pending_items.size() > 0 &&
                !(idle_mode inside {IDLE_SEND, IDLE_BOTH} && idle_now())) begin
               it = pending_items.pop_front();
               req_valid   <= 1'b1;
               req_command <= it.command;
               req_row     <= it.row;
               req_col     <= it.col;
               req_weight  <= it.weight;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= idle_mode inside {IDLE_RECV, IDLE_BOTH} ? idle_now() : 1'b0;
      end
   end

   // Monitor: predict on accepted items, check accepted phase cuts.
   always @(posedge clock) begin
      phase_cut_type exp_cut;
      req_fire <= req_valid && !req_stall && !reset;
      if (!reset && req_valid && !req_stall) begin
         if (req_command == CMD_LOAD) begin
            weights[req_row][req_col] = SUM_W'(req_weight);
            weights[req_col][req_row] = SUM_W'(req_weight);
            loads_sent++;
         end else begin
            predict_cut_run();
            starts_sent++;
         end
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         cuts_seen++;
         if (expected_cuts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected phase cut: phase %0d cut %h", rsp_phase_index,
                        rsp_cut_value);
         end else begin
            exp_cut = expected_cuts.pop_front();
            if (rsp_phase_index !== exp_cut.phase_index ||
                rsp_cut_value !== exp_cut.cut_value ||
                rsp_member_mask !== exp_cut.member_mask ||
                rsp_below_threshold !== exp_cut.below_threshold ||
                rsp_last !== exp_cut.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"cut mismatch: exp ph %0d cut %h mask %h below %b last %b",
                            " / got ph %0d cut %h mask %h below %b last %b"},
                           exp_cut.phase_index, exp_cut.cut_value, exp_cut.member_mask,
                           exp_cut.below_threshold, exp_cut.last, rsp_phase_index,
                           rsp_cut_value, rsp_member_mask, rsp_below_threshold, rsp_last);
            end
         end
      end
   end

   // Queue helpers
   task automatic push_load(int r, int c, logic [IN_W-1:0] w);
      graph_item_type it;
      it.command = CMD_LOAD;
      it.row = 4'(r);
      it.col = 4'(c);
      it.weight = w;
      planned_load[r][c] = 1;
      planned_load[c][r] = 1;
      pending_items = {pending_items, it};
   endtask

   function automatic logic [IN_W-1:0] pick_weight();
      case ($urandom_range(5))
         0: return '0;
         1: return 32'h0001_0000;                 // equal weights force ties
         2: return 32'hFFFF_FFFF;
         3: return 32'($urandom_range(4)) << 16;
         default: return $urandom;
      endcase
   endfunction

   // Load every never-written edge among the nodes in use, then start.
   task automatic push_start(int n);
      graph_item_type it;
      for (int i = 0; i < n; i++)
         for (int j = i + 1; j < n; j++)
            if (!planned_load[i][j]) push_load(i, j, pick_weight());
      it.command = CMD_START;
      it.row = 4'($urandom);
      it.col = 4'($urandom);
      it.weight = $urandom;
      pending_items = {pending_items, it};
   endtask

   // Drain: let the sequencer finish and every cut arrive, then settle.
   task automatic wait_drained();
      while (pending_items.size() > 0 || req_valid || expected_cuts.size() > 0)
         @(posedge clock);
      repeat (64) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [THR_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_NODE_COUNT) node_count_reg = value[4:0];
      else threshold_reg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random items with the node count of this phase.
   task automatic push_random(int count, int n);
      graph_item_type it;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(7) == 0) begin
            push_start(n);
         end else if ($urandom_range(15) == 0) begin
            it.row = 4'($urandom);
            push_load(it.row, it.row, $urandom);    // self edge: stored, never read
         end else begin
            push_load($urandom_range(15), $urandom_range(15), pick_weight());
         end
      end
      push_start(n);
   endtask

   initial begin
      int n_cfg;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: smallest graph, saturating extremes, out-of-range counts, ties.
      write_csr(CSR_NODE_COUNT, 32'd2);
      push_load(0, 1, 32'hFFFF_FFFF);
      push_start(2);
      push_load(0, 1, 32'd0);
      push_load(1, 1, 32'hFFFF_FFFF);
      push_start(2);
      wait_drained();
      write_csr(CSR_NODE_COUNT, 32'd0);             // clamps up to two nodes
      write_csr(CSR_THRESHOLD, 32'd0);
      push_start(2);
      wait_drained();
      write_csr(CSR_NODE_COUNT, 32'd4);
      write_csr(CSR_THRESHOLD, 32'hFFFF_FFFF);
      for (int i = 0; i < 4; i++)
         for (int j = i + 1; j < 4; j++) push_load(i, j, 32'h0001_0000);
      push_start(4);
      push_start(4);                                  // repeat start sees same matrix
      wait_drained();
      write_csr(CSR_NODE_COUNT, 32'd31);             // clamps down to sixteen
      write_csr(CSR_THRESHOLD, 32'd131072);
      push_start(16);
      wait_drained();

      // Random phases, stepping through the idling patterns.
      for (int ph = 0; ph < 8; ph++) begin
         idle_mode = ph % 4;
         case (ph)
            0: n_cfg = 16;
            1: n_cfg = 2;
            3: n_cfg = 1;
            default: n_cfg = $urandom_range(3, 15);
         endcase
         write_csr(CSR_NODE_COUNT, 32'(n_cfg));
         write_csr(CSR_THRESHOLD, ph == 2 ? 32'hFFFF_FFFF : ph == 5 ? 32'd0 :
                   ph[0] ? 32'($urandom_range(8)) << 16 : $urandom);
         push_random(20, clamp_nodes(5'(n_cfg)));
         wait_drained();
      end

      $display("Covered %0d weight loads and %0d cut runs, %0d phase cuts checked,",
               loads_sent, starts_sent, cuts_seen);
      $display("node counts 2..16 with clamping, threshold extremes, four stall patterns.");
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("timeout");
      $display("DONE: errors detected");
      $finish;
   end

endmodule
